// ===== design/adq_pkg.sv =====
// Shared types and constants for the array deque with removal.
// Used by adq_cell, adq_ctrl and array_deque_with_removal; depends on nothing.
`default_nettype none

package adq_pkg;

  localparam int unsigned DEF_CAPACITY = 16;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ_AT    = 3'd4,
    OP_REMOVE_AT  = 3'd5,
    OP_REMOVE_ALL = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_SHL  = 2'd1,
    CELL_SHR  = 2'd2
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       we;
  } cell_ctrl_t;

  typedef struct packed {
    logic        [2:0]  op;
    logic signed [31:0] value;
    logic        [3:0]  position;
  } in_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic        [1:0]  status;
    logic        [4:0]  count;
    logic        [4:0]  removed;
  } out_t;

endpackage

`default_nettype wire

// ===== design/adq_cell.sv =====
// One storage cell of the element chain: holds a word, shifts to either side
// or takes a broadcast write aimed at its own index. Depends on adq_pkg.
`default_nettype none

module adq_cell #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned INDEX = 0
) (
  input  wire logic               clk_i,
  input  wire adq_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [IDX_W-1:0]   widx_i,
  input  wire logic [31:0]        wdata_i,
  input  wire logic [31:0]        left_i,
  input  wire logic [31:0]        right_i,
  output logic      [31:0]        data_o
);

  logic [31:0] data_d, data_q;

  always_comb begin
    case (ctrl_i.mode)
      adq_pkg::CELL_SHL: data_d = right_i;
      adq_pkg::CELL_SHR: data_d = left_i;
      default:           data_d = data_q;
    endcase
    // a targeted write wins over the shift
    if (ctrl_i.we && (widx_i == IDX_W'(INDEX))) begin
      data_d = wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== design/adq_ctrl.sv =====
// Sequencer of the array deque: decodes each beat, steers the cell chain and
// runs the compaction pass through the head cell. Depends on adq_pkg.
`default_nettype none

module adq_ctrl #(
  parameter int unsigned CAPACITY = adq_pkg::DEF_CAPACITY,
  localparam int unsigned IDX_W = $clog2(CAPACITY),
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire adq_pkg::in_t        item_i,
  output logic                     busy_o,
  input  wire logic [31:0]         head_i,
  output adq_pkg::cell_ctrl_t      ctrl_o,
  output logic      [IDX_W-1:0]    widx_o,
  output logic      [31:0]         wdata_o,
  output logic                     result_valid_o,
  output adq_pkg::out_t            result_o
);

  localparam int unsigned CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam int unsigned EXT_W = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_PASS = 2'b10
  } state_e;

  state_e           state_d, state_q;
  logic [CNT_W-1:0] count_d, count_q;
  logic             res_valid_d, res_valid_q;

  logic [2:0]       kind_d, kind_q;
  logic [IDX_W-1:0] pos_d, pos_q;
  logic [31:0]      value_d, value_q;
  logic [IDX_W-1:0] step_d, step_q;
  logic [IDX_W-1:0] last_d, last_q;
  logic [IDX_W-1:0] wptr_d, wptr_q;
  logic [CNT_W-1:0] rm_d, rm_q;
  logic [31:0]      data_d, data_q;

  logic [31:0]      res_data_d, res_data_q;
  logic [1:0]       res_status_d, res_status_q;
  logic [CNT_W-1:0] res_rm_d, res_rm_q;

  logic             full, empty, bad_pos;
  logic [CMP_W-1:0] pos_x;
  logic [CNT_W-1:0] count_m1;
  logic             at_last, at_pos, drop, capture;
  logic [EXT_W-1:0] count_ext, rm_ext;

  assign full     = (count_q == CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);
  assign pos_x    = CMP_W'(item_i.position);
  assign bad_pos  = (pos_x >= CMP_W'(count_q));
  assign count_m1 = count_q - 1'b1;

  assign at_last = (step_q == last_q);
  assign at_pos  = (step_q == pos_q);

  always_comb begin
    drop    = 1'b0;
    capture = 1'b0;
    case (kind_q)
      adq_pkg::OP_POP_BACK: begin
        drop    = at_last;
        capture = at_last;
      end
      adq_pkg::OP_READ_AT: begin
        capture = at_pos;
      end
      adq_pkg::OP_REMOVE_AT: begin
        drop    = at_pos;
        capture = at_pos;
      end
      adq_pkg::OP_REMOVE_ALL: begin
        drop = (head_i == value_q);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    res_valid_d  = 1'b0;
    kind_d       = kind_q;
    pos_d        = pos_q;
    value_d      = value_q;
    step_d       = step_q;
    last_d       = last_q;
    wptr_d       = wptr_q;
    rm_d         = rm_q;
    data_d       = data_q;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;
    res_rm_d     = res_rm_q;
    ctrl_o.mode  = adq_pkg::CELL_HOLD;
    ctrl_o.we    = 1'b0;
    widx_o       = count_q[IDX_W-1:0];
    wdata_o      = item_i.value;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_data_d   = '0;
          res_status_d = adq_pkg::ST_OK;
          res_rm_d     = '0;
          // pass set-up, used by the ops that walk the chain
          kind_d  = item_i.op;
          pos_d   = pos_x[IDX_W-1:0];
          value_d = item_i.value;
          step_d  = '0;
          last_d  = count_m1[IDX_W-1:0];
          wptr_d  = count_m1[IDX_W-1:0];
          rm_d    = '0;
          data_d  = '0;
          case (item_i.op)
            adq_pkg::OP_PUSH_BACK: begin
              res_valid_d = 1'b1;
              if (full) begin
                res_status_d = adq_pkg::ST_FULL;
              end else begin
                ctrl_o.we = 1'b1;
                count_d   = count_q + 1'b1;
              end
            end
            adq_pkg::OP_PUSH_FRONT: begin
              res_valid_d = 1'b1;
              if (full) begin
                res_status_d = adq_pkg::ST_FULL;
              end else begin
                ctrl_o.mode = adq_pkg::CELL_SHR;
                count_d     = count_q + 1'b1;
              end
            end
            adq_pkg::OP_POP_FRONT: begin
              res_valid_d = 1'b1;
              if (empty) begin
                res_status_d = adq_pkg::ST_EMPTY;
              end else begin
                ctrl_o.mode = adq_pkg::CELL_SHL;
                count_d     = count_m1;
                res_data_d  = head_i;
                res_rm_d    = CNT_W'(1);
              end
            end
            adq_pkg::OP_POP_BACK: begin
              if (empty) begin
                res_valid_d  = 1'b1;
                res_status_d = adq_pkg::ST_EMPTY;
              end else begin
                state_d = S_PASS;
              end
            end
            adq_pkg::OP_READ_AT, adq_pkg::OP_REMOVE_AT: begin
              if (bad_pos) begin
                res_valid_d  = 1'b1;
                res_status_d = adq_pkg::ST_BAD_INDEX;
              end else begin
                state_d = S_PASS;
              end
            end
            adq_pkg::OP_REMOVE_ALL: begin
              if (empty) begin
                res_valid_d = 1'b1;
              end else begin
                state_d = S_PASS;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_PASS: begin
        // rotate the head out; kept words land so that the chain ends compacted
        ctrl_o.mode = adq_pkg::CELL_SHL;
        ctrl_o.we   = !drop;
        widx_o      = wptr_q;
        wdata_o     = head_i;
        step_d      = step_q + 1'b1;
        wptr_d      = drop ? (wptr_q - 1'b1) : wptr_q;
        rm_d        = rm_q + CNT_W'(drop);
        data_d      = capture ? head_i : data_q;
        if (at_last) begin
          state_d      = S_IDLE;
          count_d      = count_q - rm_d;
          res_valid_d  = 1'b1;
          res_data_d   = data_d;
          res_status_d = adq_pkg::ST_OK;
          res_rm_d     = rm_d;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    pos_q        <= pos_d;
    value_q      <= value_d;
    step_q       <= step_d;
    last_q       <= last_d;
    wptr_q       <= wptr_d;
    rm_q         <= rm_d;
    data_q       <= data_d;
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
    res_rm_q     <= res_rm_d;
  end

  // the count register already holds the post-operation value while the
  // result beat is shown
  assign count_ext = EXT_W'(count_q);
  assign rm_ext    = EXT_W'(res_rm_q);

  assign busy_o           = (state_q == S_PASS);
  assign result_valid_o   = res_valid_q;
  assign result_o.data    = res_data_q;
  assign result_o.status  = res_status_q;
  assign result_o.count   = count_ext[4:0];
  assign result_o.removed = rm_ext[4:0];

endmodule

`default_nettype wire

// ===== design/array_deque_with_removal.sv =====
// Top level of the array deque: a row of CAPACITY cells holding the words in
// front-to-back order, steered by adq_ctrl. Depends on adq_pkg, adq_cell, adq_ctrl.
`default_nettype none

// A beat is taken at a rising edge with start_i high and busy_o low. Each beat
// yields one result beat on result_o, marked by result_valid_o for a single
// cycle; the receiver cannot stall it, so it must take every result as it
// appears. Push at either end, a pop from the front, failed operations,
// remove_all on an empty list and the unused op code leave busy_o low, so the
// next beat can follow straight away. A pop from the back, read_at, remove_at
// and remove_all walk the whole held list once through the front cell of the
// chain, one word a cycle: busy_o is high for the walk and the result appears
// on the edge that ends the walk.
// No clearing pass after reset: storage cells are only read below the count.
module array_deque_with_removal #(
  parameter int unsigned CAPACITY = adq_pkg::DEF_CAPACITY
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire adq_pkg::in_t  item_i,
  output logic               busy_o,
  output logic               result_valid_o,
  output adq_pkg::out_t      result_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);

  adq_pkg::cell_ctrl_t ctrl;
  logic [IDX_W-1:0]    widx;
  logic [31:0]         wdata;
  logic [31:0]         cell_data [CAPACITY];

  adq_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .item_i        (item_i),
    .busy_o        (busy_o),
    .head_i        (cell_data[0]),
    .ctrl_o        (ctrl),
    .widx_o        (widx),
    .wdata_o       (wdata),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] left, right;

    // the front cell takes the pushed word; the back cell closes the ring
    if (i == 0) begin : g_front
      assign left = wdata;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_back
      assign right = cell_data[0];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    adq_cell #(
      .IDX_W(IDX_W),
      .INDEX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .widx_i (widx),
      .wdata_i(wdata),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[i])
    );
  end

endmodule

`default_nettype wire

// ===== tb/tb_array_deque_with_removal.sv =====
// Self-checking testbench for array_deque_with_removal: directed table, then random beats.
// Results are checked against golden table rows or a queue-based predictor kept in step.
// Depends on adq_pkg and the RTL of array_deque_with_removal only.
`timescale 1ns / 1ps

module tb_array_deque_with_removal;
  import adq_pkg::*;

  localparam int unsigned CAPACITY    = DEF_CAPACITY;
  localparam logic [2:0]  OP_UNUSED   = 3'd7;
  localparam int unsigned RANDOM_BEATS = 400;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] value;
    logic [3:0]  position;
    int          reps;
    bit          typed;
    out_t        golden;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  in_t  item_i = '0;
  logic busy_o;
  logic result_valid_o;
  out_t result_o;

  logic [31:0] held_words[$];
  out_t        expected_q[$];
  plan_row_t   plan[$];
  out_t        want;
  int unsigned idle_pct = 30;
  int unsigned errors = 0;
  int unsigned beats_sent = 0;
  int unsigned cycles = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};

  array_deque_with_removal #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .item_i        (item_i),
    .busy_o        (busy_o),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles,
               expected_q.size());
      $display("tb_array_deque_with_removal: FAIL");
      $finish;
    end
  end

  // Apply one beat to the predicted deque and return the result it should give.
  function automatic out_t deque_apply(in_t beat);
    out_t        res;
    logic [31:0] kept[$];
    int unsigned hits;
    res = '0;
    hits = 0;
    case (beat.op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (held_words.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (beat.op == OP_PUSH_BACK) begin
          held_words.insert(held_words.size(), beat.value);
        end else begin
          held_words.insert(0, beat.value);
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (held_words.size() == 0) begin
          res.status = ST_EMPTY;
        end else if (beat.op == OP_POP_BACK) begin
          res.data = held_words[held_words.size() - 1];
          held_words.delete(held_words.size() - 1);
          res.removed = 5'd1;
        end else begin
          res.data = held_words[0];
          held_words.delete(0);
          res.removed = 5'd1;
        end
      end
      OP_READ_AT, OP_REMOVE_AT: begin
        if (beat.position >= held_words.size()) begin
          res.status = ST_BAD_INDEX;
        end else begin
          res.data = held_words[beat.position];
          if (beat.op == OP_REMOVE_AT) begin
            held_words.delete(beat.position);
            res.removed = 5'd1;
          end
        end
      end
      OP_REMOVE_ALL: begin
        foreach (held_words[k]) begin
          if (held_words[k] == beat.value) hits++;
          else kept.insert(kept.size(), held_words[k]);
        end
        held_words = kept;
        res.removed = hits[4:0];
      end
      default: ;
    endcase
    res.count = 5'(held_words.size());
    return res;
  endfunction

  function automatic void plan_row(logic [2:0] op, logic [31:0] value, logic [3:0] position,
                                   int reps, bit typed, logic [31:0] data, status_e status,
                                   logic [4:0] count, logic [4:0] removed);
    plan_row_t row;
    row.op = op;
    row.value = value;
    row.position = position;
    row.reps = reps;
    row.typed = typed;
    row.golden.data = data;
    row.golden.status = status;
    row.golden.count = count;
    row.golden.removed = removed;
    plan.insert(plan.size(), row);
  endfunction

  // Hold the beat until taken, then log what it should return.
  task automatic send_beat(in_t beat, bit typed, out_t golden);
    out_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    item_i <= beat;
    do @(posedge clk_i); while (busy_o);
    predicted = deque_apply(beat);
    expected_q.insert(expected_q.size(), typed ? golden : predicted);
    beats_sent++;
  endtask

  // Drop start and wait for every outstanding result.
  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(string name, longint expd, longint got);
    if (expd != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expd, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      status_seen[result_o.status]++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual data %0d status %0d",
                 $time, result_o.data, result_o.status);
        errors++;
      end else begin
        want = expected_q[0];
        expected_q.delete(0);
        check_field("data", want.data, result_o.data);
        check_field("status", want.status, result_o.status);
        check_field("count", want.count, result_o.count);
        check_field("removed", want.removed, result_o.removed);
      end
    end
  end

  initial begin
    in_t         beat;
    out_t        none;
    bit          filling;
    int unsigned pick;
    int unsigned held;
    none = '0;
    filling = 1'b1;

    // empty-list cases, the extremes of the word, then a full list
    plan_row(OP_POP_BACK,   32'h0,         4'd0,  1, 1, 32'h0,         ST_EMPTY,     5'd0,  5'd0);
    plan_row(OP_POP_FRONT,  32'h0,         4'd0,  1, 1, 32'h0,         ST_EMPTY,     5'd0,  5'd0);
    plan_row(OP_READ_AT,    32'h0,         4'd0,  1, 1, 32'h0,         ST_BAD_INDEX, 5'd0,  5'd0);
    plan_row(OP_REMOVE_AT,  32'h0,         4'd15, 1, 1, 32'h0,         ST_BAD_INDEX, 5'd0,  5'd0);
    plan_row(OP_REMOVE_ALL, 32'h0,         4'd0,  1, 1, 32'h0,         ST_OK,        5'd0,  5'd0);
    plan_row(OP_UNUSED,     32'hFFFF_FFFF, 4'd15, 1, 1, 32'h0,         ST_OK,        5'd0,  5'd0);
    plan_row(OP_PUSH_BACK,  32'h8000_0000, 4'd0,  1, 1, 32'h0,         ST_OK,        5'd1,  5'd0);
    plan_row(OP_PUSH_FRONT, 32'h7FFF_FFFF, 4'd0,  1, 1, 32'h0,         ST_OK,        5'd2,  5'd0);
    plan_row(OP_READ_AT,    32'h0,         4'd0,  1, 1, 32'h7FFF_FFFF, ST_OK,        5'd2,  5'd0);
    plan_row(OP_READ_AT,    32'h0,         4'd1,  1, 1, 32'h8000_0000, ST_OK,        5'd2,  5'd0);
    plan_row(OP_READ_AT,    32'h0,         4'd2,  1, 1, 32'h0,         ST_BAD_INDEX, 5'd2,  5'd0);
    plan_row(OP_POP_BACK,   32'h0,         4'd0,  1, 1, 32'h8000_0000, ST_OK,        5'd1,  5'd1);
    plan_row(OP_POP_FRONT,  32'h0,         4'd0,  1, 1, 32'h7FFF_FFFF, ST_OK,        5'd0,  5'd1);
    plan_row(OP_PUSH_BACK,  32'hFFFF_FFFF, 4'd0,  8, 0, 32'h0,         ST_OK,        5'd0,  5'd0);
    plan_row(OP_PUSH_FRONT, 32'h0000_0000, 4'd0,  8, 0, 32'h0,         ST_OK,        5'd0,  5'd0);
    plan_row(OP_PUSH_BACK,  32'h5,         4'd0,  1, 1, 32'h0,         ST_FULL,      5'd16, 5'd0);
    plan_row(OP_PUSH_FRONT, 32'h5,         4'd0,  1, 1, 32'h0,         ST_FULL,      5'd16, 5'd0);
    plan_row(OP_READ_AT,    32'h0,         4'd15, 1, 1, 32'hFFFF_FFFF, ST_OK,        5'd16, 5'd0);
    plan_row(OP_REMOVE_AT,  32'h0,         4'd15, 1, 0, 32'h0,         ST_OK,        5'd0,  5'd0);
    plan_row(OP_REMOVE_AT,  32'h0,         4'd0,  1, 0, 32'h0,         ST_OK,        5'd0,  5'd0);
    plan_row(OP_REMOVE_AT,  32'h0,         4'd7,  1, 0, 32'h0,         ST_OK,        5'd0,  5'd0);
    plan_row(OP_REMOVE_ALL, 32'hFFFF_FFFF, 4'd0,  1, 0, 32'h0,         ST_OK,        5'd0,  5'd0);
    plan_row(OP_REMOVE_ALL, 32'h0,         4'd0,  1, 0, 32'h0,         ST_OK,        5'd0,  5'd0);

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[r]) begin
      for (int n = 0; n < plan[r].reps; n++) begin
        beat.op = plan[r].op;
        beat.value = plan[r].value;
        beat.position = plan[r].position;
        send_beat(beat, plan[r].typed, plan[r].golden);
      end
    end
    drain_results();

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == RANDOM_BEATS / 3 || i == 2 * RANDOM_BEATS / 3) begin
        drain_results();
        idle_pct = (i == RANDOM_BEATS / 3) ? 49 : 0;
      end
      held = held_words.size();
      // swing between filling and draining so both ends get exercised
      if (filling && held == CAPACITY && $urandom_range(0, 2) == 0) filling = 1'b0;
      if (!filling && held == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;

      pick = $urandom_range(0, 99);
      if (pick < (filling ? 60 : 15)) begin
        beat.op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 30)      beat.op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        else if (pick < 55) beat.op = OP_READ_AT;
        else if (pick < 75) beat.op = OP_REMOVE_AT;
        else if (pick < 95) beat.op = OP_REMOVE_ALL;
        else                beat.op = OP_UNUSED;
      end

      // favour repeated words so remove_all finds several matches
      case ($urandom_range(0, 3))
        0, 3: beat.value = $urandom;
        1: beat.value = (held != 0) ? held_words[$urandom_range(0, held - 1)] : $urandom;
        default: beat.value = $urandom_range(0, 3) - 1;
      endcase

      if (held != 0 && $urandom_range(0, 3) != 0) beat.position = 4'($urandom_range(0, held - 1));
      else beat.position = 4'($urandom_range(0, 15));

      send_beat(beat, 1'b0, none);
    end

    drain_results();
    repeat (CAPACITY + 4) @(posedge clk_i);

    $display("Covered %0d beats over three idle patterns, ending with %0d words held.",
             beats_sent, held_words.size());
    $display("Statuses seen: %0d ok, %0d empty, %0d full, %0d bad index; %0d errors.",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
             status_seen[ST_BAD_INDEX], errors);
    if (errors == 0) begin
      $display("tb_array_deque_with_removal: PASS");
    end else begin
      $display("tb_array_deque_with_removal: FAIL");
    end
    $finish;
  end

endmodule
